/* hw/rtl/bfhc_pkg.sv */
// shared widths, event and register codes, reset values and level constants for the heater controller
`default_nettype none

package bfhc_pkg;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned TEMP_W    = 10;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned ERR_W     = TEMP_W + 1;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [TEMP_W-1:0]  temp_t;
	typedef logic [MS_W-1:0]    ms_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam cmd_t CMD_ZERO_CROSS = 2'd0;
	localparam cmd_t CMD_MS_TICK    = 2'd1;
	localparam cmd_t CMD_TEMP       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL     = 2'd3;

	localparam temp_t  SETPOINT_RST = 10'd500;
	localparam ms_t    TIMEOUT_RST  = 16'd1500;
	localparam count_t WINDOW_RST   = 8'd100;
	localparam level_t FULL_RST     = 8'd100;

	localparam logic signed [ERR_W-1:0] ERR_HIGH = 11'sd50;
	localparam logic signed [ERR_W-1:0] ERR_MID  = 11'sd10;
	localparam logic signed [ERR_W-1:0] ERR_LOW  = -11'sd10;

	localparam level_t LEVEL_HALF = 8'd50;
	localparam level_t LEVEL_LOW  = 8'd20;

	localparam ms_t MS_MAX = {MS_W{1'b1}};

	typedef struct packed {
		logic   fire_pulse;
		logic   sample_request;
		logic   sync_lost;
		logic   alarm_start;
		level_t active_power;
		level_t next_power;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/burst_fire_heater_controller.sv */
// top level of the zero-cross burst-fire heater controller
`default_nettype none

// Burst-fire triac controller. Each accepted request is one event: a mains zero crossing,
// a millisecond tick or a temperature sample, and each gives exactly one result. A request
// can be accepted on every clock unless in_stall is high; it is captured in the input register,
// and its result is then written to the result register. Throughput is one request per cycle
// while the output is not stalled, set by the single update of the controller state between
// the two registers. A held result stalls the input only when both registers are full.
// Configuration writes are always ready and must be made while no request is in flight.

module burst_fire_heater_controller import bfhc_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,

	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire cmd_t            command,
	input  wire temp_t           temp_sample,

	output logic                 out_valid,
	input  wire                  out_stall,
	output logic                 fire_pulse,
	output logic                 sample_request,
	output logic                 sync_lost,
	output logic                 alarm_start,
	output level_t               active_power,
	output level_t               next_power,

	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_data
);

	temp_t   setpoint_q;
	ms_t     timeout_q;
	count_t  window_q;
	level_t  full_q;

	count_t  half_count_q;
	level_t  cur_power_q;
	level_t  buf_power_q;
	temp_t   last_temp_q;
	logic    lost_q;
	ms_t     ms_count_q;

	logic    valid_s1;
	cmd_t    cmd_s1;
	temp_t   temp_s1;

	result_t res_q;
	logic    advance;
	logic    process;

	level_t  level;

	count_t  half_n;
	level_t  cur_n;
	level_t  buf_n;
	temp_t   temp_n;
	logic    lost_n;
	ms_t     ms_n;
	result_t res_n;

	assign advance   = !out_valid || !out_stall;
	assign process   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	bfhc_level u_level (
		.setpoint    (setpoint_q),
		.temperature (last_temp_q),
		.full_power  (full_q),
		.level       (level)
	);

	always_comb begin
		half_n = half_count_q;
		cur_n  = cur_power_q;
		buf_n  = buf_power_q;
		temp_n = last_temp_q;
		lost_n = lost_q;
		ms_n   = ms_count_q;
		res_n  = '0;
		case (cmd_s1)
			CMD_ZERO_CROSS: begin
				ms_n   = '0;
				half_n = (lost_q ? '0 : half_count_q) + count_t'(1);
				lost_n = 1'b0;
				if (half_n >= window_q) begin
					half_n = '0;
					cur_n  = buf_power_q;
					buf_n  = level;
				end
				res_n.fire_pulse     = (half_n < cur_n);
				res_n.sample_request = !(half_n < cur_n);
			end
			CMD_MS_TICK: begin
				if (ms_count_q != MS_MAX) begin
					ms_n = ms_count_q + ms_t'(1);
				end
			end
			CMD_TEMP: begin
				temp_n = temp_s1;
			end
			default: begin
			end
		endcase
		// watchdog
		if (!lost_n && (ms_n > timeout_q)) begin
			lost_n            = 1'b1;
			half_n            = '0;
			cur_n             = '0;
			buf_n             = '0;
			res_n.alarm_start = 1'b1;
		end
		res_n.sync_lost    = lost_n;
		res_n.active_power = cur_n;
		res_n.next_power   = buf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			timeout_q  <= TIMEOUT_RST;
			window_q   <= WINDOW_RST;
			full_q     <= FULL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[TEMP_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[MS_W-1:0];
				REG_WINDOW:   window_q   <= cfg_data[COUNT_W-1:0];
				REG_FULL:     full_q     <= cfg_data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_count_q <= '0;
			cur_power_q  <= '0;
			buf_power_q  <= '0;
			last_temp_q  <= '0;
			lost_q       <= 1'b0;
			ms_count_q   <= '0;
		end else if (process) begin
			half_count_q <= half_n;
			cur_power_q  <= cur_n;
			buf_power_q  <= buf_n;
			last_temp_q  <= temp_n;
			lost_q       <= lost_n;
			ms_count_q   <= ms_n;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= command;
			temp_s1 <= temp_sample;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			res_q <= res_n;
		end
	end

	assign fire_pulse     = res_q.fire_pulse;
	assign sample_request = res_q.sample_request;
	assign sync_lost      = res_q.sync_lost;
	assign alarm_start    = res_q.alarm_start;
	assign active_power   = res_q.active_power;
	assign next_power     = res_q.next_power;

endmodule

`default_nettype wire

/* hw/rtl/bfhc_level.sv */
// power level choice from setpoint minus last temperature, clamped to full power
`default_nettype none

module bfhc_level import bfhc_pkg::*; (
	input  wire temp_t  setpoint,
	input  wire temp_t  temperature,
	input  wire level_t full_power,
	output level_t      level
);

	logic signed [ERR_W-1:0] err;
	level_t                  raw;

	always_comb begin
		err = $signed({1'b0, setpoint}) - $signed({1'b0, temperature});
		if (err > ERR_HIGH) begin
			raw = full_power;
		end else if (err > ERR_MID) begin
			raw = LEVEL_HALF;
		end else if (err > ERR_LOW) begin
			raw = LEVEL_LOW;
		end else begin
			raw = '0;
		end
		level = (raw > full_power) ? full_power : raw;
	end

endmodule

`default_nettype wire
